// ----- hw/rtl/gas_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph atlas shelf cache package
// Sizes, status codes and beat types shared by the cache and the shelf
// packer.
// ----------------------------------------------------------------------------
package gas_pkg;

  localparam int CACHE_ENTRIES = 256;
  localparam int ATLAS_WIDTH   = 1024;
  localparam int ATLAS_HEIGHT  = 1024;

  localparam int ENTRY_AW = $clog2(CACHE_ENTRIES);
  localparam int COUNT_W  = $clog2(CACHE_ENTRIES + 1);

  localparam int GLYPH_W = 16;
  localparam int DIM_W   = 11;
  localparam int POS_W   = 10;
  // Wide enough for a cursor plus a box plus a row height without overflow.
  localparam int SUM_W   = 15;

  localparam logic [1:0] ST_HIT    = 2'd0;
  localparam logic [1:0] ST_PLACED = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic [GLYPH_W-1:0] glyph_id;
    logic [DIM_W-1:0]   bmp_width;
    logic [DIM_W-1:0]   bmp_height;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [DIM_W-1:0]   box_width;
    logic [DIM_W-1:0]   box_height;
    logic               evicted;
    logic [GLYPH_W-1:0] evicted_glyph;
  } out_beat_t;

  typedef struct packed {
    logic [GLYPH_W-1:0] glyph;
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [DIM_W-1:0]   w;
    logic [DIM_W-1:0]   h;
  } entry_t;

  // Placement decision handed from the packer to the cache control.
  typedef struct packed {
    logic [1:0]       status;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [DIM_W-1:0] box_width;
    logic [DIM_W-1:0] box_height;
  } place_t;

endpackage

// ----- hw/rtl/gas_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph atlas entry RAM
// Simple dual-port synchronous RAM: one write port, one read port with the
// read data registered.
// ----------------------------------------------------------------------------
module gas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/gas_packer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph atlas shelf packer
// Holds the shelf cursor and row height, decides where a missed glyph goes
// and advances the cursor when the decision is committed.
// ----------------------------------------------------------------------------
module gas_packer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       commit,
  input  logic [gas_pkg::DIM_W-1:0]  bmp_width,
  input  logic [gas_pkg::DIM_W-1:0]  bmp_height,
  output gas_pkg::place_t            place
);

  logic [gas_pkg::DIM_W-1:0] cursor_x_r, cursor_x_nxt;
  logic [gas_pkg::DIM_W-1:0] cursor_y_r, cursor_y_nxt;
  logic [gas_pkg::DIM_W-1:0] row_h_r, row_h_nxt;

  logic                      empty;
  logic                      too_wide;
  logic                      wrap;
  logic                      too_tall;
  logic [gas_pkg::SUM_W-1:0] sum_x;
  logic [gas_pkg::SUM_W-1:0] cy;
  logic [gas_pkg::SUM_W-1:0] sum_y;
  logic [gas_pkg::DIM_W-1:0] cx;
  logic [gas_pkg::DIM_W-1:0] rh;

  always_comb begin
    empty    = (bmp_width == '0) || (bmp_height == '0);
    too_wide = gas_pkg::SUM_W'(bmp_width) > gas_pkg::SUM_W'(gas_pkg::ATLAS_WIDTH);
    sum_x    = gas_pkg::SUM_W'(cursor_x_r) + gas_pkg::SUM_W'(bmp_width);
    wrap     = sum_x > gas_pkg::SUM_W'(gas_pkg::ATLAS_WIDTH);
    cy       = wrap ? gas_pkg::SUM_W'(cursor_y_r) + gas_pkg::SUM_W'(row_h_r)
                    : gas_pkg::SUM_W'(cursor_y_r);
    cx       = wrap ? '0 : cursor_x_r;
    rh       = wrap ? '0 : row_h_r;
    sum_y    = cy + gas_pkg::SUM_W'(bmp_height);
    too_tall = sum_y > gas_pkg::SUM_W'(gas_pkg::ATLAS_HEIGHT);

    place = '0;
    if (empty) begin
      place.status = gas_pkg::ST_EMPTY;
    end else if (too_wide || too_tall) begin
      place.status = gas_pkg::ST_FULL;
    end else begin
      place.status     = gas_pkg::ST_PLACED;
      place.pos_x      = gas_pkg::POS_W'(cx);
      place.pos_y      = gas_pkg::POS_W'(cy);
      place.box_width  = bmp_width;
      place.box_height = bmp_height;
    end
  end

  // A row wrap stands even when the height test then reports a full atlas.
  always_comb begin
    cursor_x_nxt = cursor_x_r;
    cursor_y_nxt = cursor_y_r;
    row_h_nxt    = row_h_r;
    if (commit && !empty && !too_wide) begin
      cursor_y_nxt = gas_pkg::DIM_W'(cy);
      cursor_x_nxt = cx;
      row_h_nxt    = rh;
      if (!too_tall) begin
        cursor_x_nxt = gas_pkg::DIM_W'(sum_x - gas_pkg::SUM_W'(cursor_x_r)
                                       + gas_pkg::SUM_W'(cx));
        if (bmp_height > rh) begin
          row_h_nxt = bmp_height;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r <= '0;
      cursor_y_r <= '0;
      row_h_r    <= '0;
    end else begin
      cursor_x_r <= cursor_x_nxt;
      cursor_y_r <= cursor_y_nxt;
      row_h_r    <= row_h_nxt;
    end
  end

endmodule

// ----- hw/rtl/glyph_atlas_shelf_cache.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph atlas shelf cache
// Looks a glyph up in a FIFO-evicted entry ring held in RAM; on a miss it
// places the glyph with a shelf packer and appends it to the ring.
// ----------------------------------------------------------------------------
//  Channel  Ports                     Handshake
//  -------  ------------------------  -------------------------------------
//  in       start, busy, in_beat      beat taken when start && !busy
//  out      out_strobe, out_beat      beat valid for one cycle, no stall
//
// The lookup reads one ring entry per cycle from the entry RAM, so the
// single RAM read port sets the rate. A hit ends the scan at the matching
// entry; a miss reads every entry in the ring before placing the glyph,
// and an empty table goes straight to placement.
// Reset empties the ring and homes the shelf cursor; RAM contents are not
// cleared. Results cannot be stalled; the next request may start in the
// cycle its predecessor's result is shown.
// ----------------------------------------------------------------------------
module glyph_atlas_shelf_cache (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  gas_pkg::in_beat_t   in_beat,
  output logic                out_strobe,
  output gas_pkg::out_beat_t  out_beat
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_MISS = 2'd2;

  localparam int AW  = gas_pkg::ENTRY_AW;
  localparam int CW  = gas_pkg::COUNT_W;
  localparam int EW  = $bits(gas_pkg::entry_t);

  logic [1:0]                  state_r, state_nxt;
  gas_pkg::in_beat_t           req_r, req_nxt;
  logic [AW-1:0]               head_r, head_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic [CW-1:0]               idx_r, idx_nxt;
  logic                        rd_vld_r, rd_last_r, rd_first_r;
  logic                        rd_vld_nxt, rd_last_nxt, rd_first_nxt;
  logic [gas_pkg::GLYPH_W-1:0] evg_r, evg_nxt;
  logic                        out_strobe_r, out_strobe_nxt;
  gas_pkg::out_beat_t          out_beat_r, out_beat_nxt;

  logic                        accept;
  logic                        issue;
  logic                        hit;
  logic                        evict;
  logic                        do_store;
  logic                        commit;
  logic [AW:0]                 raddr_sum;
  logic [AW-1:0]               raddr;
  logic [AW-1:0]               head_after;
  logic [CW-1:0]               count_after;
  logic [AW:0]                 waddr_sum;
  logic [AW-1:0]               waddr;
  logic [EW-1:0]               rdata_raw;
  gas_pkg::entry_t             rdata;
  gas_pkg::entry_t             wentry;
  gas_pkg::place_t             place;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign commit = (state_r == S_MISS);

  gas_ram #(
    .WIDTH (EW),
    .DEPTH (gas_pkg::CACHE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (do_store),
    .waddr (waddr),
    .wdata (wentry),
    .re    (issue),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  gas_packer u_packer (
    .clk        (clk),
    .rst_n      (rst_n),
    .commit     (commit),
    .bmp_width  (req_r.bmp_width),
    .bmp_height (req_r.bmp_height),
    .place      (place)
  );

  assign rdata = gas_pkg::entry_t'(rdata_raw);

  // Ring slot addresses wrap at the table depth, which need not be a power
  // of two; both operands are below the depth, so one subtract suffices.
  always_comb begin
    raddr_sum = (AW+1)'(head_r) + (AW+1)'(idx_r[AW-1:0]);
    if (raddr_sum >= (AW+1)'(gas_pkg::CACHE_ENTRIES)) begin
      raddr_sum = raddr_sum - (AW+1)'(gas_pkg::CACHE_ENTRIES);
    end
    raddr = raddr_sum[AW-1:0];

    hit   = rd_vld_r && (state_r == S_SCAN) && (rdata.glyph == req_r.glyph_id);
    issue = (state_r == S_SCAN) && (idx_r < count_r) && !hit;

    evict = (count_r == CW'(gas_pkg::CACHE_ENTRIES));
    if (evict) begin
      head_after  = (head_r == AW'(gas_pkg::CACHE_ENTRIES - 1)) ? '0 : head_r + 1'b1;
      count_after = count_r - 1'b1;
    end else begin
      head_after  = head_r;
      count_after = count_r;
    end

    waddr_sum = (AW+1)'(head_after) + (AW+1)'(count_after[AW-1:0]);
    if (waddr_sum >= (AW+1)'(gas_pkg::CACHE_ENTRIES)) begin
      waddr_sum = waddr_sum - (AW+1)'(gas_pkg::CACHE_ENTRIES);
    end
    waddr = waddr_sum[AW-1:0];

    do_store = commit && (place.status inside {gas_pkg::ST_PLACED, gas_pkg::ST_EMPTY});

    wentry.glyph = req_r.glyph_id;
    wentry.x     = place.pos_x;
    wentry.y     = place.pos_y;
    wentry.w     = place.box_width;
    wentry.h     = place.box_height;
  end

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    evg_nxt        = evg_r;
    out_strobe_nxt = 1'b0;
    out_beat_nxt   = out_beat_r;
    rd_vld_nxt     = issue;
    rd_last_nxt    = issue && ((idx_r + 1'b1) == count_r);
    rd_first_nxt   = issue && (idx_r == '0);

    if (issue) begin
      idx_nxt = idx_r + 1'b1;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt   = in_beat;
          idx_nxt   = '0;
          state_nxt = (count_r == '0) ? S_MISS : S_SCAN;
        end
      end
      S_SCAN: begin
        // The oldest entry is read first; keep its id in case of eviction.
        if (rd_vld_r && rd_first_r) begin
          evg_nxt = rdata.glyph;
        end
        if (hit) begin
          out_strobe_nxt = 1'b1;
          out_beat_nxt   = '0;
          out_beat_nxt.status     = gas_pkg::ST_HIT;
          out_beat_nxt.pos_x      = rdata.x;
          out_beat_nxt.pos_y      = rdata.y;
          out_beat_nxt.box_width  = rdata.w;
          out_beat_nxt.box_height = rdata.h;
          state_nxt = S_IDLE;
        end else if (rd_vld_r && rd_last_r) begin
          state_nxt = S_MISS;
        end
      end
      S_MISS: begin
        head_nxt  = head_after;
        count_nxt = count_after + CW'(do_store);
        out_strobe_nxt = 1'b1;
        out_beat_nxt.status        = place.status;
        out_beat_nxt.pos_x         = place.pos_x;
        out_beat_nxt.pos_y         = place.pos_y;
        out_beat_nxt.box_width     = place.box_width;
        out_beat_nxt.box_height    = place.box_height;
        out_beat_nxt.evicted       = evict;
        out_beat_nxt.evicted_glyph = evict ? evg_r : '0;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= '0;
      count_r      <= '0;
      idx_r        <= '0;
      rd_vld_r     <= 1'b0;
      rd_last_r    <= 1'b0;
      rd_first_r   <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      count_r      <= count_nxt;
      idx_r        <= idx_nxt;
      rd_vld_r     <= rd_vld_nxt;
      rd_last_r    <= rd_last_nxt;
      rd_first_r   <= rd_first_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    evg_r      <= evg_nxt;
    out_beat_r <= out_beat_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_beat   = out_beat_r;

  // Every request yields one result, so results never come back to back.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for two cycles");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(gas_pkg::CACHE_ENTRIES))
    else $error("ring count exceeds table depth");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_beat.status == gas_pkg::ST_HIT)) |-> !out_beat.evicted)
    else $error("hit reported an eviction");

endmodule

// ----- tb/sv/glyph_atlas_shelf_cache_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph atlas shelf cache testbench
// Sends glyph requests through the start/busy port and checks every result
// beat against a behavioral copy of the cache ring and shelf packer. The run
// covers hits, placements, empty glyphs, row wraps, full-atlas rejections
// and FIFO eviction, and fills the atlas down to its last row.
// ----------------------------------------------------------------------------
module glyph_atlas_shelf_cache_tb;

  localparam int RUN_LIMIT_NS = 25_000_000;
  localparam int DRAIN_CYCLES = 300;
  localparam int RANDOM_ITEMS = 1800;
  localparam int RESET_CYCLES = 12;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  gas_pkg::in_beat_t  in_beat;
  logic               out_strobe;
  gas_pkg::out_beat_t out_beat;

  glyph_atlas_shelf_cache dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_beat   (in_beat),
    .out_strobe(out_strobe),
    .out_beat  (out_beat)
  );

  // Shadow copy of the entry ring and the shelf cursor.
  logic [gas_pkg::GLYPH_W-1:0] ring_glyph [gas_pkg::CACHE_ENTRIES];
  logic [gas_pkg::POS_W-1:0]   ring_x     [gas_pkg::CACHE_ENTRIES];
  logic [gas_pkg::POS_W-1:0]   ring_y     [gas_pkg::CACHE_ENTRIES];
  logic [gas_pkg::DIM_W-1:0]   ring_w     [gas_pkg::CACHE_ENTRIES];
  logic [gas_pkg::DIM_W-1:0]   ring_h     [gas_pkg::CACHE_ENTRIES];
  int ring_first;
  int ring_used;
  int shelf_x;
  int shelf_y;
  int shelf_height;

  gas_pkg::in_beat_t  glyph_requests[$];
  gas_pkg::out_beat_t expected_replies[$];
  int                 mismatch_count;
  int                 accepted_beats;
  bit                 beat_taken;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void append_entry(logic [gas_pkg::GLYPH_W-1:0] id, int x, int y,
                                       int w, int h);
    int slot;
    slot = (ring_first + ring_used) % gas_pkg::CACHE_ENTRIES;
    ring_glyph[slot] = id;
    ring_x[slot]     = gas_pkg::POS_W'(x);
    ring_y[slot]     = gas_pkg::POS_W'(y);
    ring_w[slot]     = gas_pkg::DIM_W'(w);
    ring_h[slot]     = gas_pkg::DIM_W'(h);
    ring_used++;
  endfunction

  function automatic gas_pkg::out_beat_t cache_place_glyph(gas_pkg::in_beat_t req);
    gas_pkg::out_beat_t rep;
    int                 slot;
    int                 i;
    int                 w;
    int                 h;
    rep = '0;
    w   = req.bmp_width;
    h   = req.bmp_height;
    for (i = 0; i < ring_used; i++) begin
      slot = (ring_first + i) % gas_pkg::CACHE_ENTRIES;
      if (ring_glyph[slot] == req.glyph_id) begin
        rep.status     = gas_pkg::ST_HIT;
        rep.pos_x      = ring_x[slot];
        rep.pos_y      = ring_y[slot];
        rep.box_width  = ring_w[slot];
        rep.box_height = ring_h[slot];
        return rep;
      end
    end
    if (ring_used >= gas_pkg::CACHE_ENTRIES) begin
      rep.evicted       = 1'b1;
      rep.evicted_glyph = ring_glyph[ring_first];
      ring_first        = (ring_first + 1) % gas_pkg::CACHE_ENTRIES;
      ring_used--;
    end
    if (w == 0 || h == 0) begin
      append_entry(req.glyph_id, 0, 0, 0, 0);
      rep.status = gas_pkg::ST_EMPTY;
      return rep;
    end
    if (w > gas_pkg::ATLAS_WIDTH) begin
      rep.status = gas_pkg::ST_FULL;
      return rep;
    end
    // The wrap to a new shelf stands even when the height test then fails.
    if (shelf_x + w > gas_pkg::ATLAS_WIDTH) begin
      shelf_x      = 0;
      shelf_y      = shelf_y + shelf_height;
      shelf_height = 0;
    end
    if (shelf_y + h > gas_pkg::ATLAS_HEIGHT) begin
      rep.status = gas_pkg::ST_FULL;
      return rep;
    end
    append_entry(req.glyph_id, shelf_x, shelf_y, w, h);
    rep.status     = gas_pkg::ST_PLACED;
    rep.pos_x      = gas_pkg::POS_W'(shelf_x);
    rep.pos_y      = gas_pkg::POS_W'(shelf_y);
    rep.box_width  = gas_pkg::DIM_W'(w);
    rep.box_height = gas_pkg::DIM_W'(h);
    shelf_x        = shelf_x + w;
    if (h > shelf_height) shelf_height = h;
    return rep;
  endfunction

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  task automatic push_glyph(int id, int w, int h);
    gas_pkg::in_beat_t beat;
    beat.glyph_id   = gas_pkg::GLYPH_W'(id);
    beat.bmp_width  = gas_pkg::DIM_W'(w);
    beat.bmp_height = gas_pkg::DIM_W'(h);
    glyph_requests.insert(glyph_requests.size(), beat);
  endtask

  task automatic wait_for_drain();
    while (glyph_requests.size() != 0 || start || expected_replies.size() != 0)
      @(posedge clk);
  endtask

  // Input side: a beat is taken when start is high and busy is low.
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      expected_replies.insert(expected_replies.size(), cache_place_glyph(in_beat));
      accepted_beats++;
      beat_taken = 1'b1;
    end
  end

  // Result side: every strobe carries exactly one result beat.
  always @(posedge clk) begin
    gas_pkg::out_beat_t exp_beat;
    if (rst_n && out_strobe) begin
      if (expected_replies.size() == 0) begin
        $error("unexpected result beat: status %0d", out_beat.status);
        mismatch_count++;
      end else begin
        exp_beat = expected_replies[0];
        expected_replies.delete(0);
        check_field("status", exp_beat.status, out_beat.status);
        check_field("pos_x", exp_beat.pos_x, out_beat.pos_x);
        check_field("pos_y", exp_beat.pos_y, out_beat.pos_y);
        check_field("box_width", exp_beat.box_width, out_beat.box_width);
        check_field("box_height", exp_beat.box_height, out_beat.box_height);
        check_field("evicted", exp_beat.evicted, out_beat.evicted);
        check_field("evicted_glyph", exp_beat.evicted_glyph, out_beat.evicted_glyph);
      end
    end
  end

  // Driver: a new beat is presented only once the previous one was taken.
  always @(negedge clk) begin
    int sender_idle;
    sender_idle = (accepted_beats < 600) ? 38 : (accepted_beats < 1200) ? 64 : 0;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || beat_taken) begin
      beat_taken = 1'b0;
      if (glyph_requests.size() != 0 && $urandom_range(0, 99) >= sender_idle) begin
        in_beat <= glyph_requests[0];
        glyph_requests.delete(0);
        start   <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  initial begin
    int n;
    int sel;
    int id;
    int w;
    int h;
    int next_row;
    mismatch_count = 0;
    accepted_beats = 0;
    beat_taken     = 1'b0;
    ring_first     = 0;
    ring_used      = 0;
    shelf_x        = 0;
    shelf_y        = 0;
    shelf_height   = 0;
    start          = 1'b0;
    in_beat        = '0;
    rst_n          = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty glyphs, hits on them, oversize boxes, wraps and edges.
    push_glyph(16'h0000, 0, 0);
    push_glyph(16'h0000, 5, 5);
    push_glyph(16'hFFFF, 0, 1024);
    push_glyph(16'h8000, 1024, 0);
    push_glyph(16'h0001, 2047, 2047);
    push_glyph(16'h0002, 1025, 1);
    push_glyph(16'h0003, 1024, 1);
    push_glyph(16'h0004, 3, 1024);
    push_glyph(16'h0005, 1, 2047);
    push_glyph(16'h0006, 1023, 2);
    push_glyph(16'h0007, 1, 1);
    push_glyph(16'h0003, 0, 0);
    push_glyph(16'h0007, 9, 9);
    push_glyph(16'h0001, 4, 4);
    push_glyph(16'hAAAA, 1020, 4);
    push_glyph(16'hFFFF, 1, 1);

    // Random: a small id pool keeps hits and evictions frequent, and small
    // boxes keep the atlas from filling before the late phases.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 85) id = $urandom_range(0, 511);
      else id = $urandom_range(0, 16'hFEFF);
      sel = $urandom_range(0, 99);
      if (sel < 6) begin
        if ($urandom_range(0, 1) == 0) begin
          w = 0;
          h = $urandom_range(0, 2047);
        end else begin
          w = $urandom_range(0, 2047);
          h = 0;
        end
      end else if (sel < 10) begin
        w = $urandom_range(1025, 2047);
        h = $urandom_range(1, 16);
      end else if (sel < 14) begin
        w = $urandom_range(1, 32);
        h = $urandom_range(1025, 2047);
      end else if (sel < 18) begin
        w = $urandom_range(33, 1024);
        h = $urandom_range(1, 16);
      end else begin
        w = $urandom_range(1, 32);
        h = $urandom_range(1, 16);
      end
      push_glyph(id, w, h);
    end

    // Fill the atlas so that the last placement lands on its bottom row.
    wait_for_drain();
    next_row = (shelf_x > 0) ? shelf_y + shelf_height : shelf_y;
    if (next_row < gas_pkg::ATLAS_HEIGHT - 1)
      push_glyph(16'hFF10, 1024, gas_pkg::ATLAS_HEIGHT - 1 - next_row);
    if (next_row <= gas_pkg::ATLAS_HEIGHT - 1)
      push_glyph(16'hFF11, 1024, 1);
    push_glyph(16'hFF12, 5, 5);
    push_glyph(16'hFF13, 0, 7);
    push_glyph(16'hFF11, 3, 3);
    push_glyph(16'hFF13, 3, 3);
    wait_for_drain();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
